/* src/afc_pkg.sv */
// ============================================================================
// afc_pkg
// Shared types, constants and tables for the affine cipher character unit.
// ============================================================================
package afc_pkg;

   // Alphabet size and symbol string (first character in the top byte).
   localparam int SymCount = 69;
   localparam logic [SymCount*8-1:0] SymString =
      "abcdefghijklmnopqrstuvwxyz,.-_ABCDEFGHIJKLMNOPQRSTUVWXYZ 0123456789()";

   // floor(p * RecipMult / 2^RecipShift) == floor(p / 69) for every 13-bit p
   localparam int RecipMult  = 7599;
   localparam int RecipShift = 19;

   // Register indexes on the configuration port
   localparam logic [1:0] RegMultKey  = 2'd0;
   localparam logic [1:0] RegShiftKey = 2'd1;
   localparam logic [1:0] RegMode     = 2'd2;

   localparam logic ModeEncrypt = 1'b0;
   localparam logic ModeDecrypt = 1'b1;

   // Key words derived from the registers, held for the pipeline
   typedef struct packed {
      logic [6:0] mult;     // a mod 69
      logic [6:0] inv;      // inverse of a mod 69, zero when none
      logic [6:0] shift;    // b mod 69
      logic       mode;
      logic       bad;      // a has no inverse
   } key_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] char_b;
      logic       found;
      logic [6:0] idx;
   } s1_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  char_b;
      logic        found;
      logic        map_en;
      logic        bad;
      logic [12:0] prod;
   } s2_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  char_b;
      logic        found;
      logic        map_en;
      logic        bad;
      logic [12:0] prod;
      logic [6:0]  quot;
   } s3_type;

   // Symbol at an alphabet index (idx below SymCount)
   function automatic logic [7:0] sym_of(input logic [6:0] idx);
      int pos;
      pos = 8 * (SymCount - 1 - int'(idx));
      return SymString[pos +: 8];
   endfunction

   // Alphabet index of a byte; lowest index wins
   function automatic logic [7:0] index_of(input logic [7:0] c);
      logic       found;
      logic [6:0] idx;
      found = 1'b0;
      idx   = '0;
      for (int k = SymCount - 1; k >= 0; k--) begin
         if (SymString[8*(SymCount-1-k) +: 8] == c) begin
            found = 1'b1;
            idx   = 7'(k);
         end
      end
      return {found, idx};
   endfunction

   // Multiplicative inverse mod 69, zero for keys sharing a factor with 69
   function automatic logic [6:0] inv_of(input logic [6:0] a);
      logic [6:0] r;
      case (a)
         7'd1:  r = 7'd1;   7'd2:  r = 7'd35;  7'd4:  r = 7'd52;  7'd5:  r = 7'd14;
         7'd7:  r = 7'd10;  7'd8:  r = 7'd26;  7'd10: r = 7'd7;   7'd11: r = 7'd44;
         7'd13: r = 7'd16;  7'd14: r = 7'd5;   7'd16: r = 7'd13;  7'd17: r = 7'd65;
         7'd19: r = 7'd40;  7'd20: r = 7'd38;  7'd22: r = 7'd22;  7'd25: r = 7'd58;
         7'd26: r = 7'd8;   7'd28: r = 7'd37;  7'd29: r = 7'd50;  7'd31: r = 7'd49;
         7'd32: r = 7'd41;  7'd34: r = 7'd67;  7'd35: r = 7'd2;   7'd37: r = 7'd28;
         7'd38: r = 7'd20;  7'd40: r = 7'd19;  7'd41: r = 7'd32;  7'd43: r = 7'd61;
         7'd44: r = 7'd11;  7'd47: r = 7'd47;  7'd49: r = 7'd31;  7'd50: r = 7'd29;
         7'd52: r = 7'd4;   7'd53: r = 7'd56;  7'd55: r = 7'd64;  7'd56: r = 7'd53;
         7'd58: r = 7'd25;  7'd59: r = 7'd62;  7'd61: r = 7'd43;  7'd62: r = 7'd59;
         7'd64: r = 7'd55;  7'd65: r = 7'd17;  7'd67: r = 7'd34;  7'd68: r = 7'd68;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

endpackage

/* src/affine_cipher_char_unit.sv */
// ============================================================================
// affine_cipher_char_unit
// Affine cipher over a 69-symbol alphabet, one character byte per beat.
// ============================================================================
// A byte taken into the stage-one register passes the stage-two, stage-three
// and output registers in turn and is taken by the receiver from the result
// ports on rsp_valid for one cycle.
// Throughput: one byte per cycle; busy never rises, since the four-stage
// pipeline has no stall and the receiver takes every result beat.
// Reset: synchronous, clears the stage valid bits and sets mult_key 1,
// shift_key 0, mode encrypt.
module affine_cipher_char_unit (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_in_char,
   // result channel
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_in_alphabet,
   output logic        rsp_key_error,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Configuration registers, kept as written (7, 7, 1 bits)
   logic [6:0]       mult_key_ff, mult_key_in;
   logic [6:0]       shift_key_ff, shift_key_in;
   logic             mode_ff, mode_in;

   // Key words derived once per cycle, held in a register so that the
   // reduction and inverse lookup stay out of the datapath stages
   afc_pkg::key_type key_ff, key_in;

   logic [1:0]       reg_idx;
   logic             cfg_wr;
   logic             accept;

   afc_pkg::s1_type  s1;
   afc_pkg::s2_type  s2;

   // ---------------------------------------------------------------------
   // Configuration port: writes complete in the access phase, no wait
   // states. Drop writes to addresses beyond the register list.
   // ---------------------------------------------------------------------
   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign cfg_wr  = psel && penable && pwrite && pready;

   always_comb begin
      mult_key_in  = mult_key_ff;
      shift_key_in = shift_key_ff;
      mode_in      = mode_ff;
      if (cfg_wr) begin
         case (reg_idx)
            afc_pkg::RegMultKey:  mult_key_in  = pwdata[6:0];
            afc_pkg::RegShiftKey: shift_key_in = pwdata[6:0];
            afc_pkg::RegMode:     mode_in      = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         afc_pkg::RegMultKey:  prdata = {25'd0, mult_key_ff};
         afc_pkg::RegShiftKey: prdata = {25'd0, shift_key_ff};
         afc_pkg::RegMode:     prdata = {31'd0, mode_ff};
         default:              prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Key derivation: reduce both keys mod 69 (one subtract suffices for a
   // 7-bit key), look up the inverse; a zero inverse marks a bad key.
   // ---------------------------------------------------------------------
   always_comb begin
      if (mult_key_ff >= 7'(afc_pkg::SymCount)) begin
         key_in.mult = mult_key_ff - 7'(afc_pkg::SymCount);
      end else begin
         key_in.mult = mult_key_ff;
      end
      if (shift_key_ff >= 7'(afc_pkg::SymCount)) begin
         key_in.shift = shift_key_ff - 7'(afc_pkg::SymCount);
      end else begin
         key_in.shift = shift_key_ff;
      end
      key_in.inv  = afc_pkg::inv_of(key_in.mult);
      key_in.bad  = (key_in.inv == 7'd0);
      key_in.mode = mode_ff;
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         mult_key_ff  <= 7'd1;
         shift_key_ff <= 7'd0;
         mode_ff      <= afc_pkg::ModeEncrypt;
      end else begin
         mult_key_ff  <= mult_key_in;
         shift_key_ff <= shift_key_in;
         mode_ff      <= mode_in;
      end
   end

   // ---------------------------------------------------------------------
   // Datapath: lookup -> affine product -> quotient -> remainder/symbol.
   // Every stage advances every cycle; valid bits travel with the beat.
   // ---------------------------------------------------------------------
   assign busy   = 1'b0;
   assign accept = start && !busy;

   afc_lookup u_lookup (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_char (req_in_char),
      .s1      (s1)
   );

   afc_affine u_affine (
      .clock (clock),
      .reset (reset),
      .key   (key_ff),
      .s1    (s1),
      .s2    (s2)
   );

   afc_reduce u_reduce (
      .clock           (clock),
      .reset           (reset),
      .s2              (s2),
      .rsp_valid       (rsp_valid),
      .rsp_out_char    (rsp_out_char),
      .rsp_in_alphabet (rsp_in_alphabet),
      .rsp_key_error   (rsp_key_error)
   );

endmodule

/* src/afc_lookup.sv */
// ============================================================================
// afc_lookup
// Stage one: capture the byte and find its alphabet index.
// ============================================================================
module afc_lookup (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      in_char,
   output afc_pkg::s1_type s1
);

   afc_pkg::s1_type s1_ff;
   afc_pkg::s1_type s1_in;
   logic [7:0]      hit;

   always_comb begin
      hit          = afc_pkg::index_of(in_char);
      s1_in.valid  = accept;
      s1_in.char_b = in_char;
      s1_in.found  = hit[7];
      s1_in.idx    = hit[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   assign s1 = s1_ff;

endmodule

/* src/afc_affine.sv */
// ============================================================================
// afc_affine
// Stage two: form the affine product before reduction.
// ============================================================================
module afc_affine (
   input  logic            clock,
   input  logic            reset,
   input  afc_pkg::key_type key,
   input  afc_pkg::s1_type s1,
   output afc_pkg::s2_type s2
);

   afc_pkg::s2_type s2_ff;
   afc_pkg::s2_type s2_in;
   logic [7:0]      diff;
   logic [6:0]      delta;
   logic [6:0]      mul_a;
   logic [6:0]      mul_b;
   logic [6:0]      addend;

   always_comb begin
      // decrypt distance (j - b) mod 69
      diff = {1'b0, s1.idx} - {1'b0, key.shift};
      if (diff[7]) begin
         delta = 7'(diff + 8'(afc_pkg::SymCount));
      end else begin
         delta = diff[6:0];
      end
      if (key.mode == afc_pkg::ModeDecrypt) begin
         mul_a  = key.inv;
         mul_b  = delta;
         addend = '0;
      end else begin
         mul_a  = key.mult;
         mul_b  = s1.idx;
         addend = key.shift;
      end
      s2_in.valid  = s1.valid;
      s2_in.char_b = s1.char_b;
      s2_in.found  = s1.found;
      s2_in.bad    = key.bad;
      s2_in.map_en = s1.found && !((key.mode == afc_pkg::ModeDecrypt) && key.bad);
      s2_in.prod   = 13'(mul_a) * 13'(mul_b) + 13'(addend);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else begin
         s2_ff <= s2_in;
      end
   end

   assign s2 = s2_ff;

endmodule

/* src/afc_reduce.sv */
// ============================================================================
// afc_reduce
// Stages three and four: reduce mod 69 and map back to a symbol.
// ============================================================================
module afc_reduce (
   input  logic            clock,
   input  logic            reset,
   input  afc_pkg::s2_type s2,
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_in_alphabet,
   output logic            rsp_key_error
);

   afc_pkg::s3_type s3_ff;
   afc_pkg::s3_type s3_in;
   logic [25:0]     recip;
   logic [12:0]     rem;
   logic            valid_ff, valid_in;
   logic [7:0]      char_ff, char_in;
   logic            found_ff, found_in;
   logic            bad_ff, bad_in;

   // quotient by reciprocal multiply
   always_comb begin
      recip          = 26'(s2.prod) * 26'(afc_pkg::RecipMult);
      s3_in.valid    = s2.valid;
      s3_in.char_b   = s2.char_b;
      s3_in.found    = s2.found;
      s3_in.map_en   = s2.map_en;
      s3_in.bad      = s2.bad;
      s3_in.prod     = s2.prod;
      s3_in.quot     = 7'(recip >> afc_pkg::RecipShift);
   end

   // remainder and symbol
   always_comb begin
      rem      = s3_ff.prod - 13'(s3_ff.quot) * 13'(afc_pkg::SymCount);
      valid_in = s3_ff.valid;
      char_in  = s3_ff.map_en ? afc_pkg::sym_of(rem[6:0]) : s3_ff.char_b;
      found_in = s3_ff.found;
      bad_in   = s3_ff.bad;
   end

   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      found_ff <= found_in;
      bad_ff   <= bad_in;
      if (reset) begin
         s3_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         s3_ff    <= s3_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_in_alphabet = found_ff;
   assign rsp_key_error   = bad_ff;

endmodule

/* src/afc_checker.sv */
// ============================================================================
// afc_checker
// Port-level checks for the affine cipher character unit.
// ============================================================================
module afc_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [7:0] req_in_char,
   input logic       rsp_valid,
   input logic [7:0] rsp_out_char,
   input logic       rsp_in_alphabet
);

   // Every result beat comes from a byte taken earlier on the input channel
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result beat without a matching input beat");

   // Bytes outside the alphabet pass through unchanged
   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_alphabet) |-> (rsp_out_char == $past(req_in_char, 4)))
      else $error("unmapped byte altered");

   // A symbol of the alphabet maps to a symbol of the alphabet, never a
   // control byte
   a_printable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_alphabet) |-> (rsp_out_char >= 8'h20))
      else $error("mapped byte outside alphabet range");

   // The pipeline never holds off the sender
   a_no_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("busy raised");

endmodule

bind affine_cipher_char_unit afc_checker u_afc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_in_char     (req_in_char),
   .rsp_valid       (rsp_valid),
   .rsp_out_char    (rsp_out_char),
   .rsp_in_alphabet (rsp_in_alphabet)
);
